// File: sv/gbpd_pkg.sv
// gain, biquad and peak detector: shared types and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gbpd_pkg;

   localparam int GAIN_W     = 16;
   localparam int ENABLE_W   = 2;
   localparam int FF_W       = 54;
   localparam int FB_W       = 36;
   localparam int PEAK_W     = 15;
   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int COEF_FRAC  = 15;
   localparam int GAIN_FRAC  = 8;

   localparam logic [PEAK_W-1:0] PEAK_MAX   = 15'h7fff;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EMPTY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HP_FF  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HP_FB  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LP_FF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LP_FB  = 3'd5;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain;
      logic [ENABLE_W-1:0] enable;
      logic [FF_W-1:0]     hp_ff;
      logic [FB_W-1:0]     hp_fb;
      logic [FF_W-1:0]     lp_ff;
      logic [FB_W-1:0]     lp_fb;
   } cfg_type;

   typedef struct packed {
      logic en;
      logic load;
      logic sub;
   } mac_op_type;

endpackage

// File: sv/gbpd_csr.sv
// gain, biquad and peak detector: configuration register file
// depends on gbpd_pkg
`timescale 1ns / 1ps

module gbpd_csr import gbpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GAIN:   cfg_in.gain   = csr_wdata[GAIN_W-1:0];
            REG_ENABLE: cfg_in.enable = csr_wdata[ENABLE_W-1:0];
            REG_HP_FF:  cfg_in.hp_ff  = csr_wdata[FF_W-1:0];
            REG_HP_FB:  cfg_in.hp_fb  = csr_wdata[FB_W-1:0];
            REG_LP_FF:  cfg_in.lp_ff  = csr_wdata[FF_W-1:0];
            REG_LP_FB:  cfg_in.lp_fb  = csr_wdata[FB_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // gain is the top field, everything else resets to zero
         cfg_ff <= {GAIN_RESET, {($bits(cfg_type) - GAIN_W){1'b0}}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/gbpd_mac.sv
// gain, biquad and peak detector: shared multiply-accumulate unit
// depends on gbpd_pkg
`timescale 1ns / 1ps

module gbpd_mac import gbpd_pkg::*; #(
   parameter int AW       = 16,
   parameter int BW       = 18,
   parameter int ACC_BITS = 36
) (
   input  logic                       clock,
   input  mac_op_type                 op,
   input  logic signed [AW-1:0]       op_a,
   input  logic signed [BW-1:0]       op_b,
   input  logic signed [ACC_BITS-1:0] base,
   output logic signed [ACC_BITS-1:0] acc
);

   logic signed [AW+BW-1:0]    prod;
   logic signed [ACC_BITS-1:0] prod_ext;
   logic signed [ACC_BITS-1:0] term;
   logic signed [ACC_BITS-1:0] start;
   logic signed [ACC_BITS-1:0] acc_ff;
   logic signed [ACC_BITS-1:0] acc_in;

   assign prod     = op_a * op_b;
   assign prod_ext = ACC_BITS'(prod);
   assign term     = op.sub ? -prod_ext : prod_ext;
   assign start    = op.load ? base : acc_ff;
   assign acc_in   = op.en ? start + term : acc_ff;
   assign acc      = acc_ff;

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// File: sv/gain_biquad_peak_detector.sv
// gain, high-pass and low-pass biquad, block peak detector: top level
// depends on gbpd_pkg, gbpd_csr, gbpd_mac
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_command, req_sample, req_last
//   rsp      out  rsp_valid/rsp_ready    rsp_peak
//   csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// a sample word runs the gain, then each enabled filter stage (high-pass before low-pass), then
// the peak update, with its products formed one at a time on the single shared multiplier
// a sample marked last then passes through the emit state, held there while rsp is stalled
// clear acts as the word is accepted; an empty-block report also passes through the emit state
// req_ready is low while a word is in work; csr writes are always taken
// synchronous active-high reset; memories and running peak reset to zero
`timescale 1ns / 1ps

module gain_biquad_peak_detector import gbpd_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18,
   parameter int MEM_BITS    = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PEAK_W-1:0]          rsp_peak,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW       = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int BW       = (COEF_BITS > GAIN_W + 1) ? COEF_BITS : GAIN_W + 1;
   localparam int PW       = AW + BW;
   localparam int ACC_BITS = ((PW > MEM_BITS) ? PW : MEM_BITS) + 2;
   localparam int FF_EXT   = (3 * COEF_BITS > FF_W) ? 3 * COEF_BITS : FF_W;
   localparam int FB_EXT   = (2 * COEF_BITS > FB_W) ? 2 * COEF_BITS : FB_W;
   localparam int MAG_W    = (SAMPLE_BITS + 1 > PEAK_W + 1) ? SAMPLE_BITS + 1 : PEAK_W + 1;

   localparam logic signed [ACC_BITS-1:0] GAIN_ROUND = ACC_BITS'(1 << (GAIN_FRAC - 1));
   localparam logic signed [ACC_BITS-1:0] COEF_ROUND = ACC_BITS'(1 << (COEF_FRAC - 1));

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_GAIN  = 12'b000000000010,
      ST_XGAIN = 12'b000000000100,
      ST_B0    = 12'b000000001000,
      ST_Y     = 12'b000000010000,
      ST_B1    = 12'b000000100000,
      ST_A1    = 12'b000001000000,
      ST_B2    = 12'b000010000000,
      ST_A2    = 12'b000100000000,
      ST_M2    = 12'b001000000000,
      ST_PEAK  = 12'b010000000000,
      ST_EMIT  = 12'b100000000000
   } state_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
      input logic signed [ACC_BITS-1:0] v
   );
      logic [ACC_BITS-SAMPLE_BITS:0] upper;
      upper = v[ACC_BITS-1:SAMPLE_BITS-1];
      if ((&upper) || !(|upper)) begin
         return v[SAMPLE_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [MEM_BITS-1:0] sat_mem(
      input logic signed [ACC_BITS-1:0] v
   );
      logic [ACC_BITS-MEM_BITS:0] upper;
      upper = v[ACC_BITS-1:MEM_BITS-1];
      if ((&upper) || !(|upper)) begin
         return v[MEM_BITS-1:0];
      end else if (v[ACC_BITS-1]) begin
         return {1'b1, {(MEM_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(MEM_BITS-1){1'b1}}};
      end
   endfunction

   cfg_type cfg;

   state_type state_ff, state_in;
   logic                          sel_ff, sel_in;
   logic signed [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic                          last_ff, last_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic [PEAK_W-1:0]             res_ff, res_in;
   logic [PEAK_W-1:0]             peak_ff, peak_in;
   logic signed [MEM_BITS-1:0]    hp_m1_ff, hp_m1_in, hp_m2_ff, hp_m2_in;
   logic signed [MEM_BITS-1:0]    lp_m1_ff, lp_m1_in, lp_m2_ff, lp_m2_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PEAK_W-1:0]             rsp_peak_ff, rsp_peak_in;

   mac_op_type                 op;
   logic signed [AW-1:0]       op_a;
   logic signed [BW-1:0]       op_b;
   logic signed [ACC_BITS-1:0] base;
   logic signed [ACC_BITS-1:0] acc;
   logic signed [ACC_BITS-1:0] acc_gain_sh;
   logic signed [ACC_BITS-1:0] acc_coef_sh;

   logic [FF_EXT-1:0]           ff_ext;
   logic [FB_EXT-1:0]           fb_ext;
   logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;
   logic signed [MEM_BITS-1:0]  m1_cur, m2_cur;

   logic signed [MAG_W-1:0] x_wide;
   logic [MAG_W-1:0]        mag;
   logic [PEAK_W-1:0]       cand;
   logic [PEAK_W-1:0]       new_peak;
   logic                    emit_go;
   logic                    req_fire;

   gbpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbpd_mac #(
      .AW       (AW),
      .BW       (BW),
      .ACC_BITS (ACC_BITS)
   ) u_mac (
      .clock (clock),
      .op    (op),
      .op_a  (op_a),
      .op_b  (op_b),
      .base  (base),
      .acc   (acc)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_peak  = rsp_peak_ff;

   // coefficient fields of the stage in work
   assign ff_ext = FF_EXT'(sel_ff ? cfg.lp_ff : cfg.hp_ff);
   assign fb_ext = FB_EXT'(sel_ff ? cfg.lp_fb : cfg.hp_fb);
   assign b0     = ff_ext[0 +: COEF_BITS];
   assign b1     = ff_ext[COEF_BITS +: COEF_BITS];
   assign b2     = ff_ext[2*COEF_BITS +: COEF_BITS];
   assign a1     = fb_ext[0 +: COEF_BITS];
   assign a2     = fb_ext[COEF_BITS +: COEF_BITS];
   assign m1_cur = sel_ff ? lp_m1_ff : hp_m1_ff;
   assign m2_cur = sel_ff ? lp_m2_ff : hp_m2_ff;

   assign acc_gain_sh = acc >>> GAIN_FRAC;
   assign acc_coef_sh = acc >>> COEF_FRAC;

   assign x_wide   = MAG_W'(x_ff);
   assign mag      = x_wide[MAG_W-1] ? MAG_W'(-x_wide) : MAG_W'(x_wide);
   assign cand     = (mag > MAG_W'(PEAK_MAX)) ? PEAK_MAX : mag[PEAK_W-1:0];
   assign new_peak = (cand > peak_ff) ? cand : peak_ff;

   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // operand select for the shared unit
   always_comb begin
      op   = '0;
      op_a = '0;
      op_b = '0;
      base = '0;
      case (state_ff)
         ST_GAIN: begin
            op.en   = 1'b1;
            op.load = 1'b1;
            op_a    = AW'(sample_ff);
            op_b    = BW'({1'b0, cfg.gain});
            base    = GAIN_ROUND;
         end
         ST_B0: begin
            op.en   = 1'b1;
            op.load = 1'b1;
            op_a    = AW'(x_ff);
            op_b    = BW'(b0);
            base    = ACC_BITS'(m1_cur) + COEF_ROUND;
         end
         ST_B1: begin
            op.en   = 1'b1;
            op.load = 1'b1;
            op_a    = AW'(x_ff);
            op_b    = BW'(b1);
            base    = ACC_BITS'(m2_cur);
         end
         ST_A1: begin
            op.en  = 1'b1;
            op.sub = 1'b1;
            op_a   = AW'(y_ff);
            op_b   = BW'(a1);
         end
         ST_B2: begin
            op.en   = 1'b1;
            op.load = 1'b1;
            op_a    = AW'(x_ff);
            op_b    = BW'(b2);
         end
         ST_A2: begin
            op.en  = 1'b1;
            op.sub = 1'b1;
            op_a   = AW'(y_ff);
            op_b   = BW'(a2);
         end
         default: begin
            op = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      res_in       = res_ff;
      peak_in      = peak_ff;
      hp_m1_in     = hp_m1_ff;
      hp_m2_in     = hp_m2_ff;
      lp_m1_in     = lp_m1_ff;
      lp_m2_in     = lp_m2_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_peak_in  = rsp_peak_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  CMD_SAMPLE: begin
                     sample_in = req_sample;
                     last_in   = req_last;
                     state_in  = ST_GAIN;
                  end
                  CMD_CLEAR: begin
                     hp_m1_in = '0;
                     hp_m2_in = '0;
                     lp_m1_in = '0;
                     lp_m2_in = '0;
                  end
                  CMD_EMPTY: begin
                     res_in   = '0;
                     peak_in  = '0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_GAIN: begin
            state_in = ST_XGAIN;
         end
         ST_XGAIN: begin
            x_in = sat_smp(acc_gain_sh);
            if (cfg.enable[0]) begin
               sel_in   = 1'b0;
               state_in = ST_B0;
            end else if (cfg.enable[1]) begin
               sel_in   = 1'b1;
               state_in = ST_B0;
            end else begin
               state_in = ST_PEAK;
            end
         end
         ST_B0: begin
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in     = sat_smp(acc_coef_sh);
            state_in = ST_B1;
         end
         ST_B1: begin
            state_in = ST_A1;
         end
         ST_A1: begin
            state_in = ST_B2;
         end
         ST_B2: begin
            if (sel_ff) begin
               lp_m1_in = sat_mem(acc);
            end else begin
               hp_m1_in = sat_mem(acc);
            end
            state_in = ST_A2;
         end
         ST_A2: begin
            state_in = ST_M2;
         end
         ST_M2: begin
            if (sel_ff) begin
               lp_m2_in = sat_mem(acc);
            end else begin
               hp_m2_in = sat_mem(acc);
            end
            x_in = y_ff;
            if (!sel_ff && cfg.enable[1]) begin
               sel_in   = 1'b1;
               state_in = ST_B0;
            end else begin
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            if (last_ff) begin
               res_in   = new_peak;
               peak_in  = '0;
               state_in = ST_EMIT;
            end else begin
               peak_in  = new_peak;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_peak_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff      <= '0;
         hp_m1_ff     <= '0;
         hp_m2_ff     <= '0;
         lp_m1_ff     <= '0;
         lp_m2_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         hp_m1_ff     <= hp_m1_in;
         hp_m2_ff     <= hp_m2_in;
         lp_m1_ff     <= lp_m1_in;
         lp_m2_ff     <= lp_m2_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      res_ff      <= res_in;
      rsp_peak_ff <= rsp_peak_in;
   end

`ifndef NO_ASSERTIONS
   a_clear_zeroes_mems : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_CLEAR) |=>
         (hp_m1_ff == '0 && hp_m2_ff == '0 && lp_m1_ff == '0 && lp_m2_ff == '0))
      else $error("filter memories not cleared by clear command");

   a_empty_goes_emit : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_EMPTY) |=> (state_ff == ST_EMIT && res_ff == '0))
      else $error("empty-block report did not queue a zero peak");

   a_peak_cleared_on_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (peak_ff == '0))
      else $error("running peak not cleared at end of block");

   a_emit_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid_ff && rsp_peak_ff == $past(res_ff)))
      else $error("result word not loaded into output register");
`endif

endmodule

// File: tb/tb_top.sv
// self-checking testbench for gain_biquad_peak_detector: directed and random words,
// random idle and stall on the req and rsp channels, a long result stall, register phases
// depends on gbpd_pkg and the gain_biquad_peak_detector rtl
`timescale 1ns / 1ps

module tb_top;
   import gbpd_pkg::*;

   localparam int COEF_W       = 18;
   localparam int STAGE_HP     = 0;
   localparam int STAGE_LP     = 1;
   localparam int SETTLE       = 48;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;

   localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   class peak_board;
      cfg_type           regs;
      longint            mem_one[2];
      longint            mem_two[2];
      logic [PEAK_W-1:0] running;
      logic [PEAK_W-1:0] peaks_due[$];
      int                errors;

      function new();
         regs = '0;
         regs.gain = GAIN_RESET;
         for (int i = 0; i < 2; i++) begin
            mem_one[i] = 0;
            mem_two[i] = 0;
         end
         running = '0;
         errors = 0;
      endfunction

      function longint clip(longint v, int bits);
         longint top;
         top = (longint'(1) <<< (bits - 1)) - 1;
         if (v > top) return top;
         if (v < -top - 1) return -top - 1;
         return v;
      endfunction

      function longint coef(logic [FF_W-1:0] word, int k);
         return longint'($signed(word[k*COEF_W +: COEF_W]));
      endfunction

      function longint filter_stage(int st, longint x, logic [FF_W-1:0] ff,
                                    logic [FB_W-1:0] fb);
         longint y;
         y = clip((coef(ff, 0) * x + mem_one[st] + (longint'(1) <<< (COEF_FRAC - 1)))
                  >>> COEF_FRAC, SAMPLE_W);
         mem_one[st] = clip(coef(ff, 1) * x - coef(FF_W'(fb), 0) * y + mem_two[st], 32);
         mem_two[st] = clip(coef(ff, 2) * x - coef(FF_W'(fb), 1) * y, 32);
         return y;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_GAIN:   regs.gain   = data[GAIN_W-1:0];
            REG_ENABLE: regs.enable = data[ENABLE_W-1:0];
            REG_HP_FF:  regs.hp_ff  = data[FF_W-1:0];
            REG_HP_FB:  regs.hp_fb  = data[FB_W-1:0];
            REG_LP_FF:  regs.lp_ff  = data[FF_W-1:0];
            REG_LP_FB:  regs.lp_fb  = data[FB_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_word(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
                              logic lst);
         longint x;
         longint mag;
         case (cmd)
            CMD_CLEAR: begin
               for (int i = 0; i < 2; i++) begin
                  mem_one[i] = 0;
                  mem_two[i] = 0;
               end
            end
            CMD_EMPTY: begin
               running = '0;
               peaks_due.push_back('0);
            end
            CMD_SAMPLE: begin
               x = longint'(smp) * longint'(regs.gain) + (longint'(1) <<< (GAIN_FRAC - 1));
               x = clip(x >>> GAIN_FRAC, SAMPLE_W);
               if (regs.enable[0]) x = filter_stage(STAGE_HP, x, regs.hp_ff, regs.hp_fb);
               if (regs.enable[1]) x = filter_stage(STAGE_LP, x, regs.lp_ff, regs.lp_fb);
               mag = (x < 0) ? -x : x;
               if (mag > longint'(PEAK_MAX)) mag = longint'(PEAK_MAX);
               if (mag > longint'(running)) running = mag[PEAK_W-1:0];
               if (lst) begin
                  peaks_due.push_back(running);
                  running = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_peak(logic [PEAK_W-1:0] actual);
         logic [PEAK_W-1:0] want;
         if (peaks_due.size() == 0) begin
            $display("%0t ns: peak expected none, actual %0d", $time, actual);
            errors++;
         end else begin
            want = peaks_due.pop_front();
            if (want !== actual) begin
               $display("%0t ns: peak expected %0d, actual %0d", $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = CMD_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample  = '0;
   logic                       req_last    = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic [PEAK_W-1:0]          rsp_peak;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index   = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;

   peak_board board = new();
   bit        idle_on = 1'b1;
   int        long_hold = 0;
   int        cycle_count = 0;

   gain_biquad_peak_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_sample  (req_sample),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_peak    (rsp_peak),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int idle_draw();
      return idle_on ? int'($urandom_range(0, 7)) : 0;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 1023) - 512;
         2: v = $urandom_range(0, 16383) - 8192;
         default: v = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_ff(logic [COEF_W-1:0] b0,
                                                     logic [COEF_W-1:0] b1,
                                                     logic [COEF_W-1:0] b2);
      return CSR_DATA_W'({b2, b1, b0});
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_fb(logic [COEF_W-1:0] a1,
                                                     logic [COEF_W-1:0] a2);
      return CSR_DATA_W'({a2, a1});
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [SAMPLE_W-1:0] smp,
                            input logic lst);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_sample  <= smp;
      req_last    <= lst;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.take_word(cmd, smp, lst);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      board.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] g, input logic [CSR_DATA_W-1:0] en,
                               input logic [CSR_DATA_W-1:0] hp_ff,
                               input logic [CSR_DATA_W-1:0] hp_fb,
                               input logic [CSR_DATA_W-1:0] lp_ff,
                               input logic [CSR_DATA_W-1:0] lp_fb);
      csr_write(REG_GAIN, g);
      csr_write(REG_ENABLE, en);
      csr_write(REG_HP_FF, hp_ff);
      csr_write(REG_HP_FB, hp_fb);
      csr_write(REG_LP_FF, lp_ff);
      csr_write(REG_LP_FB, lp_fb);
   endtask

   // wait for all peaks, then let a word that gives no peak finish
   task automatic drain();
      req_valid <= 1'b0;
      while (board.peaks_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_traffic(input int words);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) send_word(CMD_SAMPLE, pick_sample(), i == len - 1);
            sent += len;
         end else if (pick < 86) begin
            send_word(CMD_CLEAR, pick_sample(), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 93) begin
            send_word(CMD_EMPTY, pick_sample(), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 96) begin
            send_word(CMD_UNUSED, pick_sample(), 1'($urandom_range(0, 1)));
         end else begin
            send_word(CMD_SAMPLE, pick_sample(), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = idle_draw();
         if (long_hold > 0) begin
            stall = long_hold;
            long_hold = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         board.check_peak(rsp_peak);
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] hp_ff_real;
      logic [CSR_DATA_W-1:0] hp_fb_real;
      logic [CSR_DATA_W-1:0] lp_ff_real;
      logic [CSR_DATA_W-1:0] lp_fb_real;
      hp_ff_real = pack_ff(COEF_W'(29491), COEF_W'(-58982), COEF_W'(29491));
      hp_fb_real = pack_fb(COEF_W'(-58327), COEF_W'(26214));
      lp_ff_real = pack_ff(COEF_W'(655), COEF_W'(1310), COEF_W'(655));
      lp_fb_real = pack_fb(COEF_W'(-52429), COEF_W'(20972));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unity gain, no filtering
      send_word(CMD_SAMPLE, 16'sh7fff, 1'b0);
      send_word(CMD_SAMPLE, -16'sh8000, 1'b1);
      send_word(CMD_SAMPLE, 16'sh0000, 1'b1);
      send_word(CMD_SAMPLE, -16'sh0001, 1'b0);
      send_word(CMD_SAMPLE, 16'sh0001, 1'b1);
      send_word(CMD_EMPTY, 16'sh0000, 1'b0);
      send_word(CMD_UNUSED, 16'sh7fff, 1'b1);
      send_word(CMD_CLEAR, -16'sh8000, 1'b1);
      send_word(CMD_EMPTY, 16'sh7fff, 1'b1);
      send_word(CMD_SAMPLE, -16'sh0005, 1'b0);
      send_word(CMD_EMPTY, 16'sh0000, 1'b0);
      send_word(CMD_SAMPLE, 16'sh0003, 1'b1);
      drain();

      // full gain saturates
      write_config(CSR_DATA_W'(16'hffff), '0, '0, '0, '0, '0);
      send_word(CMD_SAMPLE, 16'sh7fff, 1'b0);
      send_word(CMD_SAMPLE, -16'sh8000, 1'b1);
      send_word(CMD_SAMPLE, 16'sh00c8, 1'b1);
      send_word(CMD_SAMPLE, -16'sh0081, 1'b1);
      drain();

      // plausible high-pass and low-pass chain
      write_config(CSR_DATA_W'(384), CSR_DATA_W'(3), hp_ff_real, hp_fb_real, lp_ff_real,
                   lp_fb_real);
      send_word(CMD_SAMPLE, 16'sh7fff, 1'b0);
      send_word(CMD_SAMPLE, -16'sh8000, 1'b0);
      send_word(CMD_SAMPLE, 16'sh7fff, 1'b1);
      send_word(CMD_CLEAR, 16'sh0000, 1'b0);
      send_word(CMD_SAMPLE, 16'sh03e8, 1'b1);
      random_traffic(120);
      drain();

      // zero gain, filters ring down; spare indexes change nothing
      csr_write(REG_GAIN, '0);
      csr_write(REG_SPARE_LO, rand_word());
      csr_write(REG_SPARE_HI, rand_word());
      idle_on = 1'b0;
      random_traffic(40);
      drain();

      // high-pass only, random coefficients
      idle_on = 1'b1;
      write_config(CSR_DATA_W'(256), CSR_DATA_W'(1), rand_word(), rand_word(), rand_word(),
                   rand_word());
      random_traffic(100);
      drain();

      // low-pass only, extreme coefficients
      write_config(CSR_DATA_W'(512), CSR_DATA_W'(2),
                   pack_ff(COEF_W'(131071), COEF_W'(-131072), COEF_W'(131071)),
                   pack_fb(COEF_W'(-131072), COEF_W'(131071)),
                   pack_ff(COEF_W'(-131072), COEF_W'(-131072), COEF_W'(-131072)),
                   pack_fb(COEF_W'(131071), COEF_W'(131071)));
      random_traffic(80);
      drain();

      // bypass keeps memories, then both stages resume from them
      write_config(CSR_DATA_W'(300), '0, hp_ff_real, hp_fb_real, lp_ff_real, lp_fb_real);
      random_traffic(40);
      drain();
      csr_write(REG_ENABLE, CSR_DATA_W'(3));
      random_traffic(40);
      drain();

      // long result stall while words keep coming
      idle_on = 1'b0;
      long_hold = HOLD_CYCLES;
      random_traffic(150);
      drain();

      for (int p = 0; p < 4; p++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1))
            write_config(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word());
         else
            write_config(CSR_DATA_W'($urandom_range(0, 1023)), rand_word(), hp_ff_real,
                         hp_fb_real, lp_ff_real, lp_fb_real);
         random_traffic(100);
         drain();
      end

      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
